[sv/mrc_pkg.sv]
// package for the modbus rtu reply checker
// shared types, constants and the crc-16 byte update; depends on nothing

package mrc_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_BYTE  = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    localparam logic [2:0] FRAME_LAST = 3'd6;
    localparam logic [2:0] CRC_BYTES  = 3'd5;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0] BYTE_COUNT_TWO    = 8'h02;

    localparam logic [7:0]  DEV_ADDR_RESET = 8'h01;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd100;
    localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_DEVICE_ADDRESS = 1'b0;
    localparam logic REG_TIMEOUT_MS     = 1'b1;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_BYTE,
        CMD_TICK
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_TIMEOUT,
        STATUS_CRC_ERR,
        STATUS_HDR_ERR
    } status_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
    } qentry_t;

    typedef struct packed {
        logic [7:0]  device_address;
        logic [15:0] timeout_ms;
    } cfg_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[sv/modbus_rtu_reply_checker.sv]
// top level of the modbus rtu reply checker
// instantiates mrc_regs, mrc_front and mrc_back; depends on mrc_pkg
//
//   channel  | handshake             | payload
//   ---------+-----------------------+----------------------------------
//   input    | in_valid / in_ready   | mode[1:0], rx_byte[7:0]
//   output   | out_valid / out_ready | status[1:0], distance_mm[15:0]
//   config   | apb, pready tied high | paddr[2:0], pwdata/prdata[31:0]
//
// one input transaction per cycle sustained while the queue is not full; a
// result is registered in the command queue and then in the output register
// the command queue (QDEPTH entries) absorbs input while a result is stalled
// in_ready drops only when the queue is full
// rst_n clears the control state at once; no clearing pass is needed

module modbus_rtu_reply_checker
#(
    parameter int QDEPTH = mrc_pkg::QUEUE_DEPTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     mode,
    input  logic [7:0]                     rx_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic [15:0]                    distance_mm,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mrc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mrc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mrc_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    mrc_pkg::cfg_t    cfg;
    mrc_pkg::qentry_t q_head;
    logic             q_valid;
    logic             q_pop;

    mrc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mrc_front #(.QDEPTH(QDEPTH)) u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .rx_byte  (rx_byte),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_head   (q_head)
    );

    mrc_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_head      (q_head),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .distance_mm (distance_mm)
    );

endmodule

[sv/mrc_regs.sv]
// apb configuration registers: device address and timeout
// depends on mrc_pkg

module mrc_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mrc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mrc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mrc_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output mrc_pkg::cfg_t                  cfg
);

    logic [7:0]  dev_addr_reg;
    logic [15:0] timeout_reg;
    logic        wr_en;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= mrc_pkg::DEV_ADDR_RESET;
            timeout_reg  <= mrc_pkg::TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            if (reg_sel == mrc_pkg::REG_DEVICE_ADDRESS)
            begin
                dev_addr_reg <= pwdata[7:0];
            end
            else
            begin
                timeout_reg <= pwdata[15:0];
            end
        end
    end

    always_comb
    begin
        if (reg_sel == mrc_pkg::REG_TIMEOUT_MS)
        begin
            prdata = {16'h0000, timeout_reg};
        end
        else
        begin
            prdata = {24'h000000, dev_addr_reg};
        end
    end

    assign cfg.device_address = dev_addr_reg;
    assign cfg.timeout_ms     = timeout_reg;

endmodule

[sv/mrc_front.sv]
// front end: accepts input transactions, decodes the mode into a command
// and buffers commands in a short queue for the back end; depends on mrc_pkg

module mrc_front
#(
    parameter int QDEPTH = mrc_pkg::QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       mode,
    input  logic [7:0]       rx_byte,
    output logic             q_valid,
    input  logic             q_pop,
    output mrc_pkg::qentry_t q_head
);

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);

    mrc_pkg::qentry_t q_mem_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    mrc_pkg::qentry_t entry;
    logic             keep;
    logic             push;
    logic             pop;

    // decode; unused mode codes are dropped here
    always_comb
    begin
        keep       = 1'b1;
        entry.data = rx_byte;
        entry.cmd  = mrc_pkg::CMD_START;
        case (mode)
            mrc_pkg::MODE_START: entry.cmd = mrc_pkg::CMD_START;
            mrc_pkg::MODE_BYTE:  entry.cmd = mrc_pkg::CMD_BYTE;
            mrc_pkg::MODE_TICK:  entry.cmd = mrc_pkg::CMD_TICK;
            default:             keep      = 1'b0;
        endcase
    end

    assign in_ready = (count_reg != CNT_FULL);
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_head   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

[sv/mrc_back.sv]
// back end: runs the reply state (frame capture, crc, tick timeout)
// and holds the result in an output register; depends on mrc_pkg

module mrc_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  mrc_pkg::cfg_t    cfg,
    input  logic             q_valid,
    output logic             q_pop,
    input  mrc_pkg::qentry_t q_head,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       status,
    output logic [15:0]      distance_mm
);

    logic        waiting_reg, waiting_next;
    logic [2:0]  byte_count_reg, byte_count_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [7:0]  frame_reg [6];

    logic              out_valid_reg, out_valid_next;
    mrc_pkg::status_t  status_reg, status_next;
    logic [15:0]       distance_reg, distance_next;

    logic        produce;
    logic        frame_wr;
    logic [15:0] elapsed_inc;
    logic [15:0] got_crc;
    logic        hdr_ok;

    assign q_pop       = q_valid && (!out_valid_reg || out_ready);
    assign elapsed_inc = (elapsed_reg != mrc_pkg::ELAPSED_MAX) ? elapsed_reg + 16'd1
                                                               : elapsed_reg;
    assign got_crc     = {q_head.data, frame_reg[5]};
    assign hdr_ok      = (frame_reg[0] == cfg.device_address)
                      && (frame_reg[1] == mrc_pkg::FUNC_READ_HOLDING)
                      && (frame_reg[2] == mrc_pkg::BYTE_COUNT_TWO);

    always_comb
    begin
        waiting_next    = waiting_reg;
        byte_count_next = byte_count_reg;
        crc_next        = crc_reg;
        elapsed_next    = elapsed_reg;
        produce         = 1'b0;
        frame_wr        = 1'b0;
        status_next     = mrc_pkg::STATUS_OK;
        distance_next   = 16'h0000;
        if (q_pop)
        begin
            case (q_head.cmd)
                mrc_pkg::CMD_START:
                begin
                    waiting_next    = 1'b1;
                    byte_count_next = 3'd0;
                    crc_next        = mrc_pkg::CRC_INIT;
                    elapsed_next    = 16'h0000;
                end
                mrc_pkg::CMD_BYTE:
                begin
                    if (waiting_reg && (byte_count_reg <= mrc_pkg::FRAME_LAST))
                    begin
                        byte_count_next = byte_count_reg + 3'd1;
                        if (byte_count_reg < mrc_pkg::CRC_BYTES)
                        begin
                            crc_next = mrc_pkg::crc_byte(crc_reg, q_head.data);
                        end
                        if (byte_count_reg == mrc_pkg::FRAME_LAST)
                        begin
                            waiting_next = 1'b0;
                            produce      = 1'b1;
                            if (got_crc != crc_reg)
                            begin
                                status_next = mrc_pkg::STATUS_CRC_ERR;
                            end
                            else if (!hdr_ok)
                            begin
                                status_next = mrc_pkg::STATUS_HDR_ERR;
                            end
                            else
                            begin
                                status_next   = mrc_pkg::STATUS_OK;
                                distance_next = {frame_reg[3], frame_reg[4]};
                            end
                        end
                        else
                        begin
                            frame_wr = 1'b1;
                        end
                    end
                end
                mrc_pkg::CMD_TICK:
                begin
                    if (waiting_reg)
                    begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc >= cfg.timeout_ms)
                        begin
                            waiting_next = 1'b0;
                            produce      = 1'b1;
                            status_next  = mrc_pkg::STATUS_TIMEOUT;
                        end
                    end
                end
                default:
                begin
                    produce = 1'b0;
                end
            endcase
        end
        if (produce)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg    <= 1'b0;
            byte_count_reg <= 3'd0;
            crc_reg        <= mrc_pkg::CRC_INIT;
            elapsed_reg    <= 16'h0000;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            waiting_reg    <= waiting_next;
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
            elapsed_reg    <= elapsed_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_wr)
        begin
            frame_reg[byte_count_reg] <= q_head.data;
        end
        if (produce)
        begin
            status_reg   <= status_next;
            distance_reg <= distance_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign distance_mm = distance_reg;

endmodule

[sv/mrc_checker.sv]
// port-level checker for the modbus rtu reply checker
// bound to modbus_rtu_reply_checker; depends on mrc_pkg

module mrc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [15:0] distance_mm,
    input logic        psel,
    input logic        pready
);

    // a stalled result transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(distance_mm))
        else $error("stalled result changed");

    // only an ok result carries a distance
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != mrc_pkg::STATUS_OK) |-> distance_mm == 16'h0000)
        else $error("distance on failed reply");

    // input backpressure only follows a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> $past(out_valid && !out_ready))
        else $error("input stalled without output stall");

    assert property (@(posedge clk) disable iff (!rst_n)
        psel |-> pready)
        else $error("config port not ready");

endmodule

bind modbus_rtu_reply_checker mrc_checker u_mrc_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .distance_mm (distance_mm),
    .psel        (psel),
    .pready      (pready)
);
